// ===== rtl/pcpt_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpt_pkg
// Shared widths, types and the log-sum correction table for the channel
// pair transform.
// ----------------------------------------------------------------------------
package pcpt_pkg;

  localparam int FracBits    = 8;
  localparam int CorrEntries = 64;

  localparam int DataW = 16;                // field width, Qx.FracBits
  localparam int SumW  = DataW + 1;         // sum of two fields
  localparam int DiffW = SumW + 1;          // magnitude of a difference of sums
  localparam int ResW  = SumW + 2;          // max + correction - one, before clamp
  localparam int IdxW  = (CorrEntries > 1) ? $clog2(CorrEntries) : 1;
  localparam int ProdW = DiffW + $clog2(CorrEntries + 1);
  localparam int CorrW = FracBits + 1;      // largest correction is 2^FracBits

  localparam int DataMax = (1 << (DataW - 1)) - 1;
  localparam int DataMin = -(1 << (DataW - 1));

  typedef enum logic {
    KIND_MINUS = 1'b0,
    KIND_PLUS  = 1'b1
  } kind_e;

  typedef struct packed {
    logic signed [DataW-1:0] second_log_one;
    logic signed [DataW-1:0] second_log_zero;
    logic signed [DataW-1:0] first_log_one;
    logic signed [DataW-1:0] first_log_zero;
  } pair_t;

  typedef struct packed {
    logic                    clipped;
    logic signed [DataW-1:0] combined_log_one;
    logic signed [DataW-1:0] combined_log_zero;
  } result_t;

  typedef logic [CorrW-1:0] corr_table_t [CorrEntries];

  // Bitwise integer square root, elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] vv;
    logic [63:0] res;
    logic [63:0] bval;
    vv   = v;
    res  = 64'd0;
    bval = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bval > vv) bval = bval >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bval != 64'd0) begin
        if (vv >= res + bval) begin
          vv  = vv - (res + bval);
          res = (res >> 1) + bval;
        end else begin
          res = res >> 1;
        end
        bval = bval >> 2;
      end
    end
    return res;
  endfunction

  // 2^FracBits * log2(1 + 2^(-8i/CorrEntries)), fixed-point exact procedure.
  function automatic logic [CorrW-1:0] corr_value(input int unsigned i);
    logic [63:0] x;
    logic [63:0] w;
    logic [23:0] f;
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] y;
    logic [63:0] res;
    x   = (64'(i) * 64'd8 * (64'd1 << 24)) / 64'(CorrEntries);
    w   = x >> 24;
    f   = x[23:0];
    t   = 64'd1 << 30;
    r   = 64'd1 << 29;
    res = 64'd0;
    for (int j = 1; j <= 24; j++) begin
      r = isqrt64(r << 30);
      if (f[24-j]) t = (t * r + (64'd1 << 29)) >> 30;
    end
    if (w > 64'd31) w = 64'd31;
    t = t >> w;
    y = (64'd1 << 30) + t;
    for (int j = 0; j < FracBits + 8; j++) begin
      y   = (y * y + (64'd1 << 29)) >> 30;
      res = res << 1;
      if (y >= (64'd1 << 31)) begin
        res = res | 64'd1;
        y   = y >> 1;
      end
    end
    res = (res + 64'd128) >> 8;
    return res[CorrW-1:0];
  endfunction

  function automatic corr_table_t build_corr_table();
    corr_table_t tbl;
    for (int i = 0; i < CorrEntries; i++) begin
      tbl[i] = corr_value(i);
    end
    return tbl;
  endfunction

  localparam corr_table_t CorrTable = build_corr_table();

endpackage

// ===== rtl/pcpt_log_sum.sv =====
// ----------------------------------------------------------------------------
// pcpt_log_sum
// Base-2 log-sum of two sums: max plus tabulated correction, minus one.
// ----------------------------------------------------------------------------
module pcpt_log_sum (
  input  logic signed [pcpt_pkg::SumW-1:0] a_i,
  input  logic signed [pcpt_pkg::SumW-1:0] b_i,
  output logic signed [pcpt_pkg::ResW-1:0] res_o
);

  logic                             a_gt_b;
  logic signed [pcpt_pkg::SumW-1:0] hi;
  logic        [pcpt_pkg::DiffW-1:0] diff;
  logic        [pcpt_pkg::ProdW-1:0] idx_full;
  logic        [pcpt_pkg::CorrW-1:0] corr;

  assign a_gt_b = a_i > b_i;
  assign hi     = a_gt_b ? a_i : b_i;
  assign diff   = a_gt_b ? pcpt_pkg::DiffW'($signed({a_i[pcpt_pkg::SumW-1], a_i}) -
                                            $signed({b_i[pcpt_pkg::SumW-1], b_i}))
                         : pcpt_pkg::DiffW'($signed({b_i[pcpt_pkg::SumW-1], b_i}) -
                                            $signed({a_i[pcpt_pkg::SumW-1], a_i}));

  // Scale the difference onto the table, which spans 0 to 8.0.
  assign idx_full = (pcpt_pkg::ProdW'(diff) * pcpt_pkg::ProdW'(pcpt_pkg::CorrEntries))
                    >> (pcpt_pkg::FracBits + 3);

  always_comb begin
    if (idx_full >= pcpt_pkg::ProdW'(pcpt_pkg::CorrEntries)) begin
      corr = '0;
    end else begin
      corr = pcpt_pkg::CorrTable[idx_full[pcpt_pkg::IdxW-1:0]];
    end
  end

  assign res_o = pcpt_pkg::ResW'(hi)
               + $signed(pcpt_pkg::ResW'(corr))
               - $signed(pcpt_pkg::ResW'(1) << pcpt_pkg::FracBits);

endmodule

// ===== rtl/polar_channel_pair_transform.sv =====
// ----------------------------------------------------------------------------
// polar_channel_pair_transform
// Log2-domain polar channel combining for one pair of channel outputs.
// ----------------------------------------------------------------------------
// Each word on the input stream carries two channel outputs, each as log2
// probabilities for bit 0 and bit 1 in Q8.8. In minus mode (transform_kind 0)
// each result is a base-2 log-sum of two cross sums, formed as the larger sum
// plus a 64-entry correction, minus 1.0; in plus mode (transform_kind 1) the
// results are the straight sums. Both results saturate to 16 bits and tuser
// flags saturation. Words pass an input register and a result register, with the
// full log-sum path between them; one word is taken every cycle unless the output
// stalls. Write transform_kind only while no word is in flight.
module polar_channel_pair_transform (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: transform_kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] first_log_zero, [31:16] first_log_one,
  // [47:32] second_log_zero, [63:48] second_log_one
  input  logic [63:0] s_axis_tdata_i,
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] combined_log_zero, [31:16] combined_log_one
  output logic [31:0] m_axis_tdata_o,
  // [0] clipped
  output logic        m_axis_tuser_o
);

  pcpt_pkg::kind_e   kind_q;
  logic              in_v_q;
  pcpt_pkg::pair_t   pair_q;
  logic              out_v_q;
  pcpt_pkg::result_t res_q;
  pcpt_pkg::result_t res_d;

  logic out_adv;
  logic in_adv;

  logic signed [pcpt_pkg::SumW-1:0] sum_00;  // first zero + second zero
  logic signed [pcpt_pkg::SumW-1:0] sum_11;  // first one  + second one
  logic signed [pcpt_pkg::SumW-1:0] sum_10;  // first one  + second zero
  logic signed [pcpt_pkg::SumW-1:0] sum_01;  // first zero + second one
  logic signed [pcpt_pkg::ResW-1:0] ls_zero;
  logic signed [pcpt_pkg::ResW-1:0] ls_one;
  logic signed [pcpt_pkg::ResW-1:0] raw_zero;
  logic signed [pcpt_pkg::ResW-1:0] raw_one;
  logic                             clip_zero;
  logic                             clip_one;

  // Config register: always ready, only the low bit matters.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= pcpt_pkg::KIND_MINUS;
    end else if (cfg_valid_i) begin
      kind_q <= pcpt_pkg::kind_e'(cfg_data_i);
    end
  end

  // Two-stage elastic pipeline: advance a stage whenever the next one frees up.
  assign out_adv         = !out_v_q || m_axis_tready_i;
  assign in_adv          = !in_v_q || out_adv;
  assign s_axis_tready_o = in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_adv) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid_i) begin
      pair_q <= pcpt_pkg::pair_t'(s_axis_tdata_i);
    end
  end

  // Cross sums, sign-extended by one bit.
  assign sum_00 = pcpt_pkg::SumW'(pair_q.first_log_zero) + pcpt_pkg::SumW'(pair_q.second_log_zero);
  assign sum_11 = pcpt_pkg::SumW'(pair_q.first_log_one)  + pcpt_pkg::SumW'(pair_q.second_log_one);
  assign sum_10 = pcpt_pkg::SumW'(pair_q.first_log_one)  + pcpt_pkg::SumW'(pair_q.second_log_zero);
  assign sum_01 = pcpt_pkg::SumW'(pair_q.first_log_zero) + pcpt_pkg::SumW'(pair_q.second_log_one);

  pcpt_log_sum u_ls_zero (
    .a_i   (sum_00),
    .b_i   (sum_11),
    .res_o (ls_zero)
  );

  pcpt_log_sum u_ls_one (
    .a_i   (sum_10),
    .b_i   (sum_01),
    .res_o (ls_one)
  );

  always_comb begin
    unique case (kind_q)
      pcpt_pkg::KIND_MINUS: begin
        raw_zero = ls_zero;
        raw_one  = ls_one;
      end
      pcpt_pkg::KIND_PLUS: begin
        raw_zero = pcpt_pkg::ResW'(sum_00);
        raw_one  = pcpt_pkg::ResW'(sum_11);
      end
      default: begin
        raw_zero = ls_zero;
        raw_one  = ls_one;
      end
    endcase
  end

  // Saturate each result to the field range and flag it.
  always_comb begin
    clip_zero = 1'b0;
    clip_one  = 1'b0;
    res_d.combined_log_zero = raw_zero[pcpt_pkg::DataW-1:0];
    res_d.combined_log_one  = raw_one[pcpt_pkg::DataW-1:0];
    if (raw_zero > pcpt_pkg::ResW'(pcpt_pkg::DataMax)) begin
      res_d.combined_log_zero = pcpt_pkg::DataW'(pcpt_pkg::DataMax);
      clip_zero = 1'b1;
    end else if (raw_zero < pcpt_pkg::ResW'(pcpt_pkg::DataMin)) begin
      res_d.combined_log_zero = pcpt_pkg::DataW'(pcpt_pkg::DataMin);
      clip_zero = 1'b1;
    end
    if (raw_one > pcpt_pkg::ResW'(pcpt_pkg::DataMax)) begin
      res_d.combined_log_one = pcpt_pkg::DataW'(pcpt_pkg::DataMax);
      clip_one = 1'b1;
    end else if (raw_one < pcpt_pkg::ResW'(pcpt_pkg::DataMin)) begin
      res_d.combined_log_one = pcpt_pkg::DataW'(pcpt_pkg::DataMin);
      clip_one = 1'b1;
    end
    res_d.clipped = clip_zero || clip_one;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && in_v_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {res_q.combined_log_one, res_q.combined_log_zero};
  assign m_axis_tuser_o  = res_q.clipped;

endmodule

// ===== rtl/pcpt_checker.sv =====
// ----------------------------------------------------------------------------
// pcpt_checker
// Port-level checks for the channel pair transform, bound to the top level.
// ----------------------------------------------------------------------------
module pcpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Hold a stalled output word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output word changed while stalled");

  // An empty output stage never back-pressures the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // A fresh output word comes from an input taken through the input register, then the result register.
  a_fresh_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_acc, 2))
    else $error("output appeared without a matching input");

endmodule

bind polar_channel_pair_transform pcpt_checker u_pcpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
